// ===== sv/stt_pkg.sv =====
`default_nettype none
package stt_pkg;

	// token kinds
	typedef logic [4:0] kind_t;

	localparam kind_t TK_PLUS   = 5'd0;
	localparam kind_t TK_MINUS  = 5'd1;
	localparam kind_t TK_STAR   = 5'd2;
	localparam kind_t TK_SLASH  = 5'd3;
	localparam kind_t TK_ASSIGN = 5'd4;
	localparam kind_t TK_SEMI   = 5'd5;
	localparam kind_t TK_LPAREN = 5'd6;
	localparam kind_t TK_RPAREN = 5'd7;
	localparam kind_t TK_LBRACE = 5'd8;
	localparam kind_t TK_RBRACE = 5'd9;
	localparam kind_t TK_EQ     = 5'd10;
	localparam kind_t TK_NE     = 5'd11;
	localparam kind_t TK_LT     = 5'd12;
	localparam kind_t TK_LE     = 5'd13;
	localparam kind_t TK_GT     = 5'd14;
	localparam kind_t TK_GE     = 5'd15;
	localparam kind_t TK_AND    = 5'd16;
	localparam kind_t TK_OR     = 5'd17;
	localparam kind_t TK_NOT    = 5'd18;
	localparam kind_t TK_COMMA  = 5'd19;
	localparam kind_t TK_KW0    = 5'd20;
	localparam kind_t TK_NUMBER = 5'd24;
	localparam kind_t TK_IDENT  = 5'd25;
	localparam kind_t TK_END    = 5'd26;

	// keyword table, text right-aligned, first character highest
	localparam int KW_CHARS = 28;
	localparam int KW_POS_W = 5;
	typedef logic [KW_CHARS*8-1:0] kw_text_t;
	typedef logic [KW_POS_W-1:0]   kw_pos_t;

	localparam kw_text_t KW0_TEXT = "Freestayla";
	localparam kw_text_t KW1_TEXT = "Rakamakafo";
	localparam kw_text_t KW2_TEXT = 224'h497A756D5F466163746F72;
	localparam kw_text_t KW3_TEXT = 224'h566F76615F4149626F6C69745F4C65636869745F676F766E6F636F64;

	typedef struct packed {
		logic  v;
		kind_t k;
	} opt_kind_t;

	// one result word, run_last travels beside it
	typedef struct packed {
		kind_t       kind;
		logic [31:0] value;
		logic        ovf;
		logic [7:0]  ich;
		logic        tend;
	} res_t;

	typedef enum logic [1:0] {SEL_NONE, SEL_PFX, SEL_A, SEL_B} sel_t;

	typedef struct packed {
		logic    take;
		sel_t    sel;
		kw_pos_t pfx_idx;
		logic    last;
		logic    commit;
	} ctrl_cmd_t;

	typedef struct packed {
		kw_pos_t pfx_cnt;
		logic    a_valid;
		logic    b_valid;
		logic    out_free;
	} ctrl_stat_t;

	function automatic kw_text_t kw_text(input logic [1:0] id);
		case (id)
			2'd0: return KW0_TEXT;
			2'd1: return KW1_TEXT;
			2'd2: return KW2_TEXT;
			default: return KW3_TEXT;
		endcase
	endfunction

	function automatic kw_pos_t kw_len(input logic [1:0] id);
		case (id)
			2'd0: return 5'd10;
			2'd1: return 5'd10;
			2'd2: return 5'd11;
			default: return 5'd28;
		endcase
	endfunction

	function automatic logic [7:0] kw_char(input logic [1:0] id, input kw_pos_t pos);
		kw_text_t t;
		kw_pos_t  n;
		kw_pos_t  r;
		t = kw_text(id);
		n = kw_len(id);
		r = n - 5'd1 - pos;
		if (pos < n) begin
			return t[{r, 3'b000} +: 8];
		end
		return 8'h00;
	endfunction

	function automatic opt_kind_t single_kind(input logic [7:0] c);
		opt_kind_t r;
		r.v = 1'b1;
		r.k = TK_PLUS;
		case (c)
			"+": r.k = TK_PLUS;
			"-": r.k = TK_MINUS;
			"*": r.k = TK_STAR;
			"/": r.k = TK_SLASH;
			"=": r.k = TK_ASSIGN;
			";": r.k = TK_SEMI;
			"(": r.k = TK_LPAREN;
			")": r.k = TK_RPAREN;
			"{": r.k = TK_LBRACE;
			"}": r.k = TK_RBRACE;
			"<": r.k = TK_LT;
			">": r.k = TK_GT;
			"!": r.k = TK_NOT;
			",": r.k = TK_COMMA;
			default: r.v = 1'b0;
		endcase
		return r;
	endfunction

	function automatic opt_kind_t pair_kind(input logic [7:0] a, input logic [7:0] b);
		opt_kind_t r;
		r.v = 1'b1;
		r.k = TK_EQ;
		if (b == "=" && a == "=") r.k = TK_EQ;
		else if (b == "=" && a == "!") r.k = TK_NE;
		else if (b == "=" && a == "<") r.k = TK_LE;
		else if (b == "=" && a == ">") r.k = TK_GE;
		else if (a == "&" && b == "&") r.k = TK_AND;
		else if (a == "|" && b == "|") r.k = TK_OR;
		else r.v = 1'b0;
		return r;
	endfunction

	function automatic res_t tok_res(input kind_t k);
		res_t r;
		r = '0;
		r.kind = k;
		r.tend = 1'b1;
		return r;
	endfunction

	function automatic res_t ident_res(input logic [7:0] ch, input logic tend);
		res_t r;
		r = '0;
		r.kind = TK_IDENT;
		r.ich = ch;
		r.tend = tend;
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== sv/stt_if.sv =====
`default_nettype none
// character channel
interface stt_char_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] ch;

	modport source (output valid, output action, output ch, input ready);
	modport sink (input valid, input action, input ch, output ready);
endinterface

// token channel
interface stt_token_if;
	logic        valid;
	logic        ready;
	logic [4:0]  token_kind;
	logic [31:0] number_value;
	logic        number_overflow;
	logic [7:0]  ident_char;
	logic        token_end;
	logic        run_last;

	modport source (output valid, output token_kind, output number_value,
		output number_overflow, output ident_char, output token_end, output run_last,
		input ready);
	modport sink (input valid, input token_kind, input number_value,
		input number_overflow, input ident_char, input token_end, input run_last,
		output ready);
endinterface
`default_nettype wire

// ===== sv/stt_ctrl.sv =====
`default_nettype none
module stt_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire stt_pkg::ctrl_stat_t stat,
	output stt_pkg::ctrl_cmd_t      cmd
);

	typedef enum logic [1:0] {ST_IDLE, ST_PFX, ST_A, ST_B} state_t;

	state_t           state_q;
	stt_pkg::kw_pos_t k_q;

	logic want_pfx;
	logic want_a;
	logic want_b;
	logic want_any;
	logic pfx_final;
	logic go;

	always_comb begin
		want_pfx = (state_q == ST_PFX) && (k_q < stat.pfx_cnt);
		want_a = !want_pfx && (state_q == ST_PFX || state_q == ST_A) && stat.a_valid;
		want_b = !want_pfx && !want_a && (state_q != ST_IDLE) && stat.b_valid;
		want_any = want_pfx || want_a || want_b;
		pfx_final = ({1'b0, k_q} + 6'd1) == {1'b0, stat.pfx_cnt};
		go = want_any && stat.out_free;

		cmd.take = item_valid && (state_q == ST_IDLE);
		cmd.pfx_idx = k_q;
		if (!go) cmd.sel = stt_pkg::SEL_NONE;
		else if (want_pfx) cmd.sel = stt_pkg::SEL_PFX;
		else if (want_a) cmd.sel = stt_pkg::SEL_A;
		else cmd.sel = stt_pkg::SEL_B;
		cmd.last = (want_pfx && pfx_final && !stat.a_valid && !stat.b_valid)
			|| (want_a && !stat.b_valid) || want_b;
		cmd.commit = (state_q != ST_IDLE) && ((go && cmd.last) || !want_any);
	end

	assign item_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.take) begin
						state_q <= ST_PFX;
						k_q <= '0;
					end
				end
				default: begin
					if (cmd.commit) begin
						state_q <= ST_IDLE;
					end else if (go && want_pfx) begin
						k_q <= k_q + 5'd1;
					end else if (go && want_a) begin
						state_q <= ST_B;
					end
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/stt_datapath.sv =====
`default_nettype none
module stt_datapath #(
	parameter int NUMBER_BITS = 32,
	parameter int IDENT_MAX = 255
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_action,
	input  wire logic [7:0]          item_ch,
	input  wire stt_pkg::ctrl_cmd_t  cmd,
	output stt_pkg::ctrl_stat_t      stat,
	output logic                     res_valid,
	input  wire logic                res_ready,
	output stt_pkg::res_t            res,
	output logic                     res_last
);

	localparam int IW = $clog2(IDENT_MAX + 1);
	localparam int NB = NUMBER_BITS;

	typedef enum logic [2:0] {MD_IDLE, MD_LEAD, MD_KEYWORD, MD_NUMBER, MD_IDENT} mode_t;

	// latched item
	logic       item_action_q;
	logic [7:0] item_ch_q;

	// scanner state
	mode_t            mode_q;
	logic [7:0]       lead_q;
	logic [1:0]       kw_id_q;
	stt_pkg::kw_pos_t kw_pos_q;
	logic [NB-1:0]    acc_q;
	logic             sat_q;
	logic [IW-1:0]    ilen_q;
	logic [7:0]       held_q;

	// next scanner state
	mode_t            n_mode;
	logic [7:0]       n_lead;
	logic [1:0]       n_kw_id;
	stt_pkg::kw_pos_t n_kw_pos;
	logic [NB-1:0]    n_acc;
	logic             n_sat;
	logic [IW-1:0]    n_ilen;
	logic [7:0]       n_held;

	// output register
	logic          res_valid_q;
	stt_pkg::res_t res_q;
	logic          res_last_q;

	logic [7:0]         c;
	logic               c_space;
	logic               c_lead;
	logic               c_digit;
	logic               c_alpha;
	logic               c_ident;
	stt_pkg::opt_kind_t c_single;
	stt_pkg::opt_kind_t lead_single;
	stt_pkg::opt_kind_t pair;
	logic               kw_start;
	logic [1:0]         kw_start_id;

	mode_t          st_mode;
	logic           do_start;

	stt_pkg::kw_pos_t kw_len_cur;
	stt_pkg::kw_pos_t kw_n1;
	stt_pkg::kw_pos_t kw_n;
	stt_pkg::kw_pos_t kw_pfx;
	logic [7:0]       kw_held;
	logic             kw_room;
	logic             kw_match;
	logic             kw_done;

	logic [NB+3:0] num_wide;
	logic [NB+3:0] num_prod;
	logic          num_ovf;
	stt_pkg::res_t num_res;

	logic          a_valid;
	logic          b_valid;
	stt_pkg::res_t a_res;
	stt_pkg::res_t b_res;
	stt_pkg::res_t sel_res;

	// character classes and start-of-token decode
	always_comb begin
		c = item_ch_q;
		c_space = c inside {8'h20, [8'h09:8'h0D]};
		c_lead = c inside {"=", "!", "<", ">", "&", "|"};
		c_digit = c inside {["0":"9"]};
		c_alpha = c inside {["a":"z"], ["A":"Z"]};
		c_ident = c_alpha || c_digit || (c == "_");
		c_single = stt_pkg::single_kind(c);
		lead_single = stt_pkg::single_kind(lead_q);
		pair = stt_pkg::pair_kind(lead_q, c);

		kw_start = 1'b0;
		kw_start_id = 2'd0;
		for (int i = 3; i >= 0; i--) begin
			if (stt_pkg::kw_char(2'(i), 5'd0) == c) begin
				kw_start = 1'b1;
				kw_start_id = 2'(i);
			end
		end

		if (c_space) st_mode = MD_IDLE;
		else if (c_lead) st_mode = MD_LEAD;
		else if (c_single.v) st_mode = MD_IDLE;
		else if (c_digit) st_mode = MD_NUMBER;
		else if (kw_start) st_mode = MD_KEYWORD;
		else if (c_alpha || c == "_") st_mode = MD_IDENT;
		else st_mode = MD_IDLE;
	end

	// keyword prefix handling and number step
	always_comb begin
		kw_len_cur = stt_pkg::kw_len(kw_id_q);
		kw_n1 = (kw_pos_q < kw_len_cur) ? kw_pos_q : kw_len_cur;
		kw_n = ({3'b000, kw_n1} > 8'(IDENT_MAX)) ? 5'(IDENT_MAX) : kw_n1;
		kw_pfx = (kw_n == 5'd0) ? 5'd0 : kw_n - 5'd1;
		kw_held = stt_pkg::kw_char(kw_id_q, kw_pfx);
		kw_room = {3'b000, kw_n} < 8'(IDENT_MAX);
		kw_match = (kw_pos_q < kw_len_cur) && (stt_pkg::kw_char(kw_id_q, kw_pos_q) == c);
		kw_done = ({1'b0, kw_pos_q} + 6'd1) >= {1'b0, kw_len_cur};

		// acc * 10 + digit as two shifts and adds
		num_wide = {4'b0000, acc_q};
		num_prod = (num_wide << 3) + (num_wide << 1) + (NB+4)'(c[3:0]);
		num_ovf = sat_q || (num_prod[NB+3:NB] != 4'd0);

		num_res = stt_pkg::tok_res(stt_pkg::TK_NUMBER);
		num_res.value = 32'(acc_q);
		num_res.ovf = sat_q;
	end

	// result plan and next state for the latched item
	always_comb begin
		n_mode = mode_q;
		n_lead = lead_q;
		n_kw_id = kw_id_q;
		n_kw_pos = kw_pos_q;
		n_acc = acc_q;
		n_sat = sat_q;
		n_ilen = ilen_q;
		n_held = held_q;
		a_valid = 1'b0;
		a_res = '0;
		b_valid = 1'b0;
		b_res = '0;
		do_start = 1'b0;
		stat.pfx_cnt = 5'd0;

		if (item_action_q) begin
			// end of source: flush, end token, back to reset state
			b_valid = 1'b1;
			b_res = stt_pkg::tok_res(stt_pkg::TK_END);
			n_mode = MD_IDLE;
			n_lead = 8'h00;
			n_kw_id = 2'd0;
			n_kw_pos = 5'd0;
			n_acc = '0;
			n_sat = 1'b0;
			n_ilen = '0;
			n_held = 8'h00;
			case (mode_q)
				MD_LEAD: begin
					a_valid = lead_single.v;
					a_res = stt_pkg::tok_res(lead_single.k);
				end
				MD_KEYWORD: begin
					stat.pfx_cnt = kw_pfx;
					a_valid = 1'b1;
					a_res = stt_pkg::ident_res(kw_held, 1'b1);
				end
				MD_NUMBER: begin
					a_valid = 1'b1;
					a_res = num_res;
				end
				MD_IDENT: begin
					a_valid = (ilen_q != '0);
					a_res = stt_pkg::ident_res(held_q, 1'b1);
				end
				default: begin
				end
			endcase
		end else begin
			case (mode_q)
				MD_LEAD: begin
					if (pair.v) begin
						a_valid = 1'b1;
						a_res = stt_pkg::tok_res(pair.k);
						n_mode = MD_IDLE;
					end else begin
						// lone ampersand or bar has no single kind and drops out
						a_valid = lead_single.v;
						a_res = stt_pkg::tok_res(lead_single.k);
						do_start = 1'b1;
					end
				end
				MD_KEYWORD: begin
					if (kw_match) begin
						n_kw_pos = kw_pos_q + 5'd1;
						if (kw_done) begin
							a_valid = 1'b1;
							a_res = stt_pkg::tok_res(stt_pkg::TK_KW0 + 5'(kw_id_q));
							n_mode = MD_IDLE;
							n_kw_pos = 5'd0;
							n_kw_id = 2'd0;
						end
					end else begin
						// broken keyword: prefix replays as identifier characters
						stat.pfx_cnt = kw_pfx;
						n_kw_pos = 5'd0;
						n_kw_id = 2'd0;
						n_mode = MD_IDENT;
						if (c_ident) begin
							if (kw_room) begin
								a_valid = 1'b1;
								a_res = stt_pkg::ident_res(kw_held, 1'b0);
								n_held = c;
								n_ilen = IW'(kw_n) + IW'(1);
							end else begin
								n_held = kw_held;
								n_ilen = IW'(kw_n);
							end
						end else begin
							a_valid = 1'b1;
							a_res = stt_pkg::ident_res(kw_held, 1'b1);
							do_start = 1'b1;
						end
					end
				end
				MD_NUMBER: begin
					if (c_digit) begin
						n_acc = num_ovf ? '1 : num_prod[NB-1:0];
						n_sat = num_ovf;
					end else begin
						a_valid = 1'b1;
						a_res = num_res;
						do_start = 1'b1;
					end
				end
				MD_IDENT: begin
					if (c_ident) begin
						if (ilen_q < IW'(IDENT_MAX)) begin
							a_valid = 1'b1;
							a_res = stt_pkg::ident_res(held_q, 1'b0);
							n_held = c;
							n_ilen = ilen_q + IW'(1);
						end
					end else begin
						a_valid = (ilen_q != '0);
						a_res = stt_pkg::ident_res(held_q, 1'b1);
						do_start = 1'b1;
					end
				end
				default: begin
					do_start = 1'b1;
				end
			endcase

			if (do_start) begin
				// fields of modes other than st_mode are never read
				n_mode = st_mode;
				b_valid = (st_mode == MD_IDLE) && !c_space && !c_lead && c_single.v;
				b_res = stt_pkg::tok_res(c_single.k);
				n_lead = c;
				n_acc = NB'(c[3:0]);
				n_sat = 1'b0;
				n_kw_id = kw_start_id;
				n_kw_pos = 5'd1;
				n_ilen = IW'(1);
				n_held = c;
			end
		end

		stat.a_valid = a_valid;
		stat.b_valid = b_valid;
		stat.out_free = !res_valid_q || res_ready;
	end

	always_comb begin
		case (cmd.sel)
			stt_pkg::SEL_PFX: sel_res = stt_pkg::ident_res(stt_pkg::kw_char(kw_id_q, cmd.pfx_idx),
				1'b0);
			stt_pkg::SEL_A: sel_res = a_res;
			stt_pkg::SEL_B: sel_res = b_res;
			default: sel_res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MD_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				mode_q <= n_mode;
			end
			if (cmd.sel != stt_pkg::SEL_NONE) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			item_action_q <= item_action;
			item_ch_q <= item_ch;
		end
		if (cmd.commit) begin
			lead_q <= n_lead;
			kw_id_q <= n_kw_id;
			kw_pos_q <= n_kw_pos;
			acc_q <= n_acc;
			sat_q <= n_sat;
			ilen_q <= n_ilen;
			held_q <= n_held;
		end
		if (cmd.sel != stt_pkg::SEL_NONE) begin
			res_q <= sel_res;
			res_last_q <= cmd.last;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;
	assign res_last = res_last_q;

endmodule
`default_nettype wire

// ===== sv/source_text_tokenizer.sv =====
`default_nettype none
// channel  side    word fields
// -------  ------  -------------------------------------------------------------
// chars    sink    action(1) ch(8)
// tokens   source  token_kind(5) number_value(32) number_overflow(1)
//                  ident_char(8) token_end(1) run_last(1)
//
// an input word is latched while the controller is idle, and the next word is taken
// once every token word it produces is in the output register; a broken keyword
// replays up to 26 prefix characters as identifier words, one per cycle while the
// output register is free; the single output register sets the one-word-per-cycle
// pace; arst_n clears the controller and the scanner mode; the output register stays
// valid until tokens.ready, and chars.ready is low while a word is being worked
module source_text_tokenizer #(
	parameter int NUMBER_BITS = 32,
	parameter int IDENT_MAX = 255
) (
	input wire logic    clk,
	input wire logic    arst_n,
	stt_char_if.sink    chars,
	stt_token_if.source tokens
);

	// command and status between controller and datapath
	stt_pkg::ctrl_cmd_t  cmd;
	stt_pkg::ctrl_stat_t stat;

	stt_pkg::res_t res;
	logic          res_valid;
	logic          res_last;

	// controller: accept, walk prefix characters, then up to two tail words
	stt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (chars.valid),
		.item_ready (chars.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// datapath: scanner state, result plan, keyword table, output register
	stt_datapath #(
		.NUMBER_BITS (NUMBER_BITS),
		.IDENT_MAX   (IDENT_MAX)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_action (chars.action),
		.item_ch     (chars.ch),
		.cmd         (cmd),
		.stat        (stat),
		.res_valid   (res_valid),
		.res_ready   (tokens.ready),
		.res         (res),
		.res_last    (res_last)
	);

	// token word out of the output register
	assign tokens.valid = res_valid;
	assign tokens.token_kind = res.kind;
	assign tokens.number_value = res.value;
	assign tokens.number_overflow = res.ovf;
	assign tokens.ident_char = res.ich;
	assign tokens.token_end = res.tend;
	assign tokens.run_last = res_last;

endmodule
`default_nettype wire
